### rtl/core/assert_macros.svh
// Assertion helpers shared by the decoder RTL.
// LCW_ASSERT checks on every rising edge outside reset.
// LCW_ASSERT_NR checks on every rising edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lcw: assertion failed");
`define LCW_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lcw: assertion failed");
`else
`define LCW_ASSERT(lbl, clk, rstn, prop)
`define LCW_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### rtl/core/lcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lcw_pkg;

  // Default history size in bytes
  localparam int unsigned HISTORY_DEPTH_DEF = 65536;
  // Result queue depth
  localparam int unsigned OQ_DEPTH = 3;

  // Request kinds
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // Opcode values and fields
  localparam logic [7:0] OP_EXIT    = 8'h80;
  localparam logic [7:0] OP_FILL    = 8'hFE;
  localparam logic [7:0] OP_LCOPY   = 8'hFF;
  localparam logic [7:0] LONG_FLAG  = 8'h80;
  localparam logic [7:0] ABS_FLAG   = 8'h40;
  localparam logic [7:0] COUNT_MASK = 8'h3F;
  localparam logic [7:0] RELHI_MASK = 8'h0F;
  localparam logic [15:0] RUN_BIAS  = 16'd3;
  localparam logic [15:0] LEN_RESET = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_OPCODE   = 4'd0,
    PH_REL_LO   = 4'd1,
    PH_SIZE_LO  = 4'd2,
    PH_SIZE_HI  = 4'd3,
    PH_FILL_VAL = 4'd4,
    PH_OFF_LO   = 4'd5,
    PH_OFF_HI   = 4'd6,
    PH_LIT_WAIT = 4'd7,
    PH_LIT_HELD = 4'd8,
    PH_COPY     = 4'd9,
    PH_FILL     = 4'd10
  } lcw_phase_e;

  // Decoded request on its way to the history stage
  typedef struct packed {
    logic        valid;
    logic        has;
    logic        use_mem;
    logic        bad;
    logic [7:0]  lit_data;
    logic        need;
    logic        finished;
    logic [15:0] count;
  } lcw_s1_t;

  // One result item
  typedef struct packed {
    logic [15:0] out_count;
    logic        bad_reference;
    logic        finished;
    logic        needs_source;
    logic [7:0]  data_byte;
    logic        has_byte;
  } lcw_res_t;

endpackage
`default_nettype wire

### rtl/core/lcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lcw_ctrl #(
  parameter int unsigned HISTORY_DEPTH = lcw_pkg::HISTORY_DEPTH_DEF,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_data_i,
  input  wire logic            acc_i,
  input  wire logic            cmd_i,
  input  wire logic [7:0]      src_i,
  output logic                 rd_en_o,
  output logic [AW-1:0]        rd_addr_o,
  output lcw_pkg::lcw_s1_t     s1_o,
  output logic [AW-1:0]        waddr_o
);
  import lcw_pkg::*;

  localparam logic [16:0]   DEPTH_W = 17'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(HISTORY_DEPTH - 1);

  lcw_phase_e    ph_q, ph_d;
  logic [7:0]    op_q, op_d;
  logic [15:0]   run_left_q, rl_d;
  logic [15:0]   copy_q, copy_d;
  logic [7:0]    fill_q, fill_d;
  logic          done_q, done_d;
  logic [15:0]   wp_q, wp_d;
  logic [AW-1:0] wpm_q, wpm_d;
  logic [15:0]   len_q;
  lcw_s1_t       s1_q, s1_d;
  logic [AW-1:0] waddr_q, waddr_d;

  logic          done0, emit, cp_ok;
  logic [15:0]   rem, sz, clip, rl_dec, lag;
  logic [16:0]   back;
  lcw_phase_e    start_ph;
  logic          in_run;

  // Clip a run to the bytes left before the length limit
  always_comb begin
    rem   = len_q - wp_q;
    sz    = (ph_q == PH_OPCODE) ? {8'b0, src_i & COUNT_MASK} : run_left_q;
    clip  = (sz > rem) ? rem : sz;
    done0 = done_q | (wp_q >= len_q);
    rl_dec = (run_left_q != '0) ? run_left_q - 16'd1 : '0;
  end

  // Validate the copy position and map it into the history ring
  always_comb begin
    lag   = wp_q - copy_q;
    cp_ok = (copy_q < wp_q) && ({1'b0, lag} <= DEPTH_W);
    back  = 17'(wpm_q) + DEPTH_W - {1'b0, lag};
    rd_addr_o = (back >= DEPTH_W) ? AW'(back - DEPTH_W) : AW'(back);
  end

  // Next state of the decoder for one accepted request
  always_comb begin
    ph_d     = ph_q;
    op_d     = op_q;
    rl_d     = run_left_q;
    copy_d   = copy_q;
    fill_d   = fill_q;
    done_d   = done_q;
    wp_d     = wp_q;
    wpm_d    = wpm_q;
    s1_d     = '0;
    waddr_d  = waddr_q;
    rd_en_o  = 1'b0;
    emit     = 1'b0;
    start_ph = PH_OPCODE;
    if (acc_i) begin
      s1_d.valid = 1'b1;
      waddr_d    = wpm_q;
      done_d     = done0;
      if (!done0) begin
        if (cmd_i == CMD_FEED) begin
          case (ph_q)
            PH_OPCODE: begin
              op_d = src_i;
              if (src_i == OP_EXIT) begin
                done_d = 1'b1;
              end else if ((src_i & LONG_FLAG) == '0) begin
                copy_d = {4'b0, src_i[3:0] & RELHI_MASK[3:0], 8'b0};
                rl_d   = {12'b0, src_i[7:4]} + RUN_BIAS;
                ph_d   = PH_REL_LO;
              end else if (src_i == OP_FILL || src_i == OP_LCOPY) begin
                rl_d = '0;
                ph_d = PH_SIZE_LO;
              end else if ((src_i & ABS_FLAG) != '0) begin
                rl_d = {8'b0, src_i & COUNT_MASK} + RUN_BIAS;
                ph_d = PH_OFF_LO;
              end else begin
                start_ph = PH_LIT_WAIT;
                rl_d     = clip;
                ph_d     = (clip != '0) ? start_ph : PH_OPCODE;
              end
            end
            PH_REL_LO: begin
              copy_d = wp_q - {copy_q[15:8], src_i};
              rl_d   = clip;
              ph_d   = (clip != '0) ? PH_COPY : PH_OPCODE;
            end
            PH_SIZE_LO: begin
              rl_d = {8'b0, src_i};
              ph_d = PH_SIZE_HI;
            end
            PH_SIZE_HI: begin
              rl_d = {src_i, run_left_q[7:0]};
              ph_d = (op_q == OP_FILL) ? PH_FILL_VAL : PH_OFF_LO;
            end
            PH_FILL_VAL: begin
              fill_d = src_i;
              rl_d   = clip;
              ph_d   = (clip != '0) ? PH_FILL : PH_OPCODE;
            end
            PH_OFF_LO: begin
              copy_d = {8'b0, src_i};
              ph_d   = PH_OFF_HI;
            end
            PH_OFF_HI: begin
              copy_d = {src_i, copy_q[7:0]};
              rl_d   = clip;
              ph_d   = (clip != '0) ? PH_COPY : PH_OPCODE;
            end
            PH_LIT_WAIT: begin
              fill_d = src_i;
              ph_d   = PH_LIT_HELD;
            end
            default: begin
            end
          endcase
        end else begin
          case (ph_q)
            PH_LIT_HELD: begin
              emit          = 1'b1;
              s1_d.lit_data = fill_q;
              ph_d          = (rl_dec != '0) ? PH_LIT_WAIT : PH_OPCODE;
            end
            PH_FILL: begin
              emit          = 1'b1;
              s1_d.lit_data = fill_q;
              ph_d          = (rl_dec != '0) ? PH_FILL : PH_OPCODE;
            end
            PH_COPY: begin
              emit         = 1'b1;
              s1_d.use_mem = cp_ok;
              s1_d.bad     = !cp_ok;
              rd_en_o      = cp_ok;
              copy_d       = copy_q + 16'd1;
              ph_d         = (rl_dec != '0) ? PH_COPY : PH_OPCODE;
            end
            default: begin
            end
          endcase
        end
        // advance the write position on every emitted byte
        if (emit) begin
          wp_d  = wp_q + 16'd1;
          wpm_d = (wpm_q == LAST_IX) ? '0 : wpm_q + AW'(1);
          rl_d  = rl_dec;
        end
        if (wp_d >= len_q) begin
          done_d = 1'b1;
        end
      end
      s1_d.has      = emit;
      s1_d.need     = !done_d && (ph_d inside {[PH_OPCODE:PH_LIT_WAIT]});
      s1_d.finished = done_d;
      s1_d.count    = wp_d;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q       <= PH_OPCODE;
      op_q       <= '0;
      run_left_q <= '0;
      copy_q     <= '0;
      fill_q     <= '0;
      done_q     <= 1'b0;
      wp_q       <= '0;
      wpm_q      <= '0;
      len_q      <= LEN_RESET;
      s1_q       <= '0;
    end else begin
      ph_q       <= ph_d;
      op_q       <= op_d;
      run_left_q <= rl_d;
      copy_q     <= copy_d;
      fill_q     <= fill_d;
      done_q     <= done_d;
      wp_q       <= wp_d;
      wpm_q      <= wpm_d;
      s1_q       <= s1_d;
      if (cfg_we_i) begin
        len_q <= cfg_data_i;
      end
    end
  end

  // Write address travels with the request, no reset needed
  always_ff @(posedge clk_i) begin
    waddr_q <= waddr_d;
  end

  assign s1_o    = s1_q;
  assign waddr_o = waddr_q;

  // Phases that emit bytes on a pull
  assign in_run = ph_q inside {PH_LIT_HELD, PH_COPY, PH_FILL};

  `LCW_ASSERT(a_done_sticky, clk_i, rst_ni, done_q |=> done_q)
  `LCW_ASSERT(a_feed_no_emit, clk_i, rst_ni, (acc_i && (cmd_i == CMD_FEED)) |=> $stable(wp_q))
  `LCW_ASSERT(a_run_live, clk_i, rst_ni, (!done_q && in_run) |-> (run_left_q != '0))

endmodule
`default_nettype wire

### rtl/core/lcw_hist.sv
`timescale 1ns / 1ps
`default_nettype none
module lcw_hist #(
  parameter int unsigned HISTORY_DEPTH = lcw_pkg::HISTORY_DEPTH_DEF,
  localparam int unsigned AW = $clog2(HISTORY_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  input  wire lcw_pkg::lcw_s1_t  s1_i,
  input  wire logic [AW-1:0]     waddr_i,
  output logic                   push_o,
  output lcw_pkg::lcw_res_t      res_o
);
  import lcw_pkg::*;

  logic [7:0] mem [HISTORY_DEPTH];
  logic [7:0] rdata_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q;
  logic [7:0] wdata;
  logic       we;

  // Resolve the byte: zero for a bad reference, copy data from memory or bypass, else the literal
  always_comb begin
    we = s1_i.valid && s1_i.has;
    if (s1_i.bad) begin
      wdata = '0;
    end else if (s1_i.use_mem) begin
      wdata = fwd_q ? fwd_data_q : rdata_q;
    end else begin
      wdata = s1_i.lit_data;
    end
  end

  // History store: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr_i] <= wdata;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
    fwd_data_q <= wdata;
  end

  // Bypass when the read hits the byte written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= rd_en_i && we && (waddr_i == rd_addr_i);
    end
  end

  assign push_o = s1_i.valid;
  always_comb begin
    res_o.has_byte      = s1_i.has;
    res_o.data_byte     = wdata;
    res_o.needs_source  = s1_i.need;
    res_o.finished      = s1_i.finished;
    res_o.bad_reference = s1_i.bad;
    res_o.out_count     = s1_i.count;
  end

endmodule
`default_nettype wire

### rtl/core/lcw_outq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lcw_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire lcw_pkg::lcw_res_t  res_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output lcw_pkg::lcw_res_t       res_o,
  output logic [1:0]              cnt_o
);
  import lcw_pkg::*;

  localparam logic [1:0] LAST_PTR = 2'(OQ_DEPTH - 1);

  lcw_res_t   buf_q [OQ_DEPTH];
  logic [1:0] wr_q, rd_q, cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign res_o   = buf_q[rd_q];
  assign cnt_o   = cnt_q;

  // Store results in arrival order
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= res_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 2'd1;
      end
      if (pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  `LCW_ASSERT_NR(a_oq_bound, clk_i, (cnt_q <= 2'(OQ_DEPTH)))

endmodule
`default_nettype wire

### rtl/core/lcw_format80_decompressor.sv
// LCW (format80) stream decoder, one request per cycle while the input is ready.
// A taken request is registered into the history stage, then pushed into the
// result queue, from which the receiver takes it.
// Throughput: one request per cycle while the receiver keeps up; the input holds
// off while the history stage and the three-entry result queue hold three results.
// Reset: control state clears and out_length returns to 65535; history is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module lcw_format80_decompressor #(
  parameter int unsigned HISTORY_DEPTH = lcw_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,     // out_length
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] src_byte
  input  wire logic        s_axis_tuser,   // [0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [0] has_byte, [8:1] data_byte,
                                           // [9] needs_source, [10] finished,
                                           // [11] bad_reference, [27:12] out_count
);
  import lcw_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic          acc;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] waddr;
  lcw_s1_t       s1;
  lcw_res_t      res, res_out;
  logic          push;
  logic [1:0]    oq_cnt;
  logic [2:0]    occ;

  // Take a request only while the queue can absorb everything in flight
  assign occ           = {1'b0, oq_cnt} + {2'b0, s1.valid};
  assign s_axis_tready = (occ <= 3'(OQ_DEPTH - 1));
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  lcw_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .cmd_i      (s_axis_tuser),
    .src_i      (s_axis_tdata),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .s1_o       (s1),
    .waddr_o    (waddr)
  );

  lcw_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .s1_i      (s1),
    .waddr_i   (waddr),
    .push_o    (push),
    .res_o     (res)
  );

  lcw_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out),
    .cnt_o   (oq_cnt)
  );

  // Pack the result, has_byte lowest and out_count highest
  assign m_axis_tdata = {4'b0, res_out.out_count, res_out.bad_reference, res_out.finished,
                         res_out.needs_source, res_out.data_byte, res_out.has_byte};

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lcw_pkg::*;

  localparam int DIR_ROWS = 28;

  // One row of the directed table: request, and a typed result where obvious
  typedef struct packed {
    logic       cmd;
    logic [7:0] src;
    logic       typed;
    lcw_res_t   res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] src_byte
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [0] has_byte, [8:1] data_byte, [9] needs_source,
                               // [10] finished, [11] bad_reference, [27:12] out_count

  lcw_format80_decompressor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Decoder shadow state
  logic [7:0]  hist_mem [0:65535];
  int unsigned wr_pos;
  lcw_phase_e  dec_phase;
  logic [7:0]  op_hold;
  int unsigned run_cnt;
  int unsigned src_pos;
  logic [7:0]  held_byte;
  bit          dec_done;
  int unsigned len_limit;

  lcw_res_t    pending_results [$];
  int unsigned err_count;
  bit          gaps_on;
  int unsigned rx_hold_req;
  logic [15:0] abs_target;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("lcw_format80_decompressor test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic lcw_res_t result_of(bit has, bit [7:0] data, bit need, bit fin,
                                         bit bad, bit [15:0] cnt);
    lcw_res_t r;
    r.has_byte      = has;
    r.data_byte     = data;
    r.needs_source  = need;
    r.finished      = fin;
    r.bad_reference = bad;
    r.out_count     = cnt;
    return r;
  endfunction

  // End decoding once the length limit is met
  function automatic void check_length_end();
    if (!dec_done && wr_pos >= len_limit) begin
      dec_done  = 1'b1;
      dec_phase = PH_OPCODE;
      run_cnt   = 0;
    end
  endfunction

  // Clip a run to the bytes left and enter its phase, or fall back to opcode
  function automatic void begin_run(int unsigned size, lcw_phase_e ph);
    int unsigned rem;
    rem       = (len_limit > wr_pos) ? len_limit - wr_pos : 0;
    run_cnt   = (size > rem) ? rem : size;
    dec_phase = (run_cnt != 0) ? ph : PH_OPCODE;
  endfunction

  function automatic void store_byte(logic [7:0] v);
    hist_mem[wr_pos[15:0]] = v;
    wr_pos = (wr_pos + 1) & 32'hFFFF;
    if (run_cnt != 0)
      run_cnt--;
  endfunction

  function automatic void take_source(logic [7:0] b);
    case (dec_phase)
      PH_OPCODE: begin
        op_hold = b;
        if (b == OP_EXIT) begin
          dec_done = 1'b1;
        end else if ((b & LONG_FLAG) == 8'h00) begin
          src_pos   = int'(b & RELHI_MASK) << 8;
          run_cnt   = int'(b >> 4) + RUN_BIAS;
          dec_phase = PH_REL_LO;
        end else if (b == OP_FILL || b == OP_LCOPY) begin
          run_cnt   = 0;
          dec_phase = PH_SIZE_LO;
        end else if ((b & ABS_FLAG) != 8'h00) begin
          run_cnt   = int'(b & COUNT_MASK) + RUN_BIAS;
          dec_phase = PH_OFF_LO;
        end else begin
          begin_run(int'(b & COUNT_MASK), PH_LIT_WAIT);
        end
      end
      PH_REL_LO: begin
        src_pos = (wr_pos - (src_pos | int'(b))) & 32'hFFFF;
        begin_run(run_cnt, PH_COPY);
      end
      PH_SIZE_LO: begin
        run_cnt   = int'(b);
        dec_phase = PH_SIZE_HI;
      end
      PH_SIZE_HI: begin
        run_cnt   = run_cnt | (int'(b) << 8);
        dec_phase = (op_hold == OP_FILL) ? PH_FILL_VAL : PH_OFF_LO;
      end
      PH_FILL_VAL: begin
        held_byte = b;
        begin_run(run_cnt, PH_FILL);
      end
      PH_OFF_LO: begin
        src_pos   = int'(b);
        dec_phase = PH_OFF_HI;
      end
      PH_OFF_HI: begin
        src_pos = src_pos | (int'(b) << 8);
        begin_run(run_cnt, PH_COPY);
      end
      PH_LIT_WAIT: begin
        held_byte = b;
        dec_phase = PH_LIT_HELD;
      end
      default: ;
    endcase
  endfunction

  // Advance the shadow decoder by one request and return its result
  function automatic lcw_res_t decode_step(logic cmd, logic [7:0] b);
    lcw_res_t r;
    r = '0;
    check_length_end();
    if (!dec_done) begin
      if (cmd == CMD_FEED) begin
        take_source(b);
      end else if (dec_phase == PH_LIT_HELD) begin
        r.has_byte  = 1'b1;
        r.data_byte = held_byte;
        store_byte(held_byte);
        dec_phase = (run_cnt != 0) ? PH_LIT_WAIT : PH_OPCODE;
      end else if (dec_phase == PH_FILL) begin
        r.has_byte  = 1'b1;
        r.data_byte = held_byte;
        store_byte(held_byte);
        if (run_cnt == 0)
          dec_phase = PH_OPCODE;
      end else if (dec_phase == PH_COPY) begin
        // only positions already written may be read back
        if (src_pos < wr_pos)
          r.data_byte = hist_mem[src_pos[15:0]];
        else
          r.bad_reference = 1'b1;
        r.has_byte = 1'b1;
        src_pos = (src_pos + 1) & 32'hFFFF;
        store_byte(r.data_byte);
        if (run_cnt == 0)
          dec_phase = PH_OPCODE;
      end
      check_length_end();
    end
    r.needs_source = !dec_done && (dec_phase <= PH_LIT_WAIT);
    r.finished     = dec_done;
    r.out_count    = wr_pos[15:0];
    return r;
  endfunction

  // Pick a plausible compressed byte for the phase the decoder is in
  function automatic logic [7:0] pick_source_byte();
    logic [7:0] v;
    int unsigned sel;
    v = 8'($urandom_range(255));
    sel = $urandom_range(99);
    case (dec_phase)
      PH_OPCODE: begin
        if (sel < 30)
          v = {1'b0, 3'($urandom_range(7)),
               ($urandom_range(99) < 60) ? 4'h0 : 4'($urandom_range(15))};
        else if (sel < 45)
          v = OP_FILL;
        else if (sel < 55)
          v = OP_LCOPY;
        else if (sel < 75)
          v = 8'($urandom_range(8'hFD, 8'hC0));
        else
          v = 8'($urandom_range(8'hBF, 8'h81));
      end
      PH_REL_LO: begin
        if (src_pos == 0 && wr_pos != 0 && sel < 70)
          v = 8'($urandom_range((wr_pos > 255) ? 255 : wr_pos, 1));
      end
      PH_SIZE_LO: begin
        if (sel < 85)
          v = 8'($urandom_range(40));
      end
      PH_SIZE_HI: begin
        v = (sel < 5) ? 8'h01 : 8'h00;
      end
      PH_OFF_LO: begin
        if (wr_pos != 0 && sel < 70)
          abs_target = 16'($urandom_range(wr_pos - 1));
        else
          abs_target = 16'($urandom());
        v = abs_target[7:0];
      end
      PH_OFF_HI: begin
        v = abs_target[15:8];
      end
      default: ;
    endcase
    return v;
  endfunction

  // Offer one request, hold it until taken, then record what it should yield
  task automatic send_request(input logic cmd, input logic [7:0] b, input bit typed,
                              input lcw_res_t typed_res);
    lcw_res_t predicted;
    while (gaps_on && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = decode_step(cmd, b);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_length(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    len_limit = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Feed while the decoder waits for source, pull while it emits
  task automatic send_wellformed();
    if (dec_phase <= PH_LIT_WAIT)
      send_request(CMD_FEED, pick_source_byte(), 1'b0, '0);
    else
      send_request(CMD_PULL, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic finish_operation();
    while (dec_phase != PH_OPCODE)
      send_wellformed();
  endtask

  // Mostly well-formed streams, with some wrong-kind requests mixed in
  task automatic run_random(input int n);
    int count;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 8) begin
        if (dec_phase <= PH_LIT_WAIT)
          send_request(CMD_PULL, 8'($urandom_range(255)), 1'b0, '0);
        else
          send_request(CMD_FEED, 8'($urandom_range(255)), 1'b0, '0);
      end else begin
        send_wellformed();
        count++;
      end
    end
  endtask

  function automatic dir_row_t dir_row(int i);
    dir_row_t r;
    r = '0;
    case (i)
      0:  r = {CMD_PULL, 8'h00, 1'b1, result_of(0, 8'h00, 1, 0, 0, 16'd0)};
      1:  r = {CMD_FEED, 8'h82, 1'b0, 28'h0};  // literal run of two
      2:  r = {CMD_FEED, 8'hFF, 1'b0, 28'h0};
      3:  r = {CMD_FEED, 8'h55, 1'b0, 28'h0};  // dropped while a literal is held
      4:  r = {CMD_PULL, 8'h00, 1'b1, result_of(1, 8'hFF, 1, 0, 0, 16'd1)};
      5:  r = {CMD_FEED, 8'h00, 1'b0, 28'h0};
      6:  r = {CMD_PULL, 8'h00, 1'b1, result_of(1, 8'h00, 1, 0, 0, 16'd2)};
      7:  r = {CMD_PULL, 8'hFF, 1'b1, result_of(0, 8'h00, 1, 0, 0, 16'd2)};
      8:  r = {CMD_FEED, 8'h00, 1'b0, 28'h0};  // relative copy of three
      9:  r = {CMD_FEED, 8'h02, 1'b0, 28'h0};
      10: r = {CMD_PULL, 8'h00, 1'b0, 28'h0};
      11: r = {CMD_PULL, 8'h00, 1'b0, 28'h0};
      12: r = {CMD_PULL, 8'h00, 1'b0, 28'h0};
      13: r = {CMD_FEED, 8'h00, 1'b0, 28'h0};  // relative copy, offset zero
      14: r = {CMD_FEED, 8'h00, 1'b0, 28'h0};
      15: r = {CMD_PULL, 8'h00, 1'b1, result_of(1, 8'h00, 0, 0, 1, 16'd6)};
      16: r = {CMD_PULL, 8'h00, 1'b0, 28'h0};
      17: r = {CMD_PULL, 8'h00, 1'b0, 28'h0};
      18: r = {CMD_FEED, 8'hC0, 1'b0, 28'h0};  // absolute copy across the top
      19: r = {CMD_FEED, 8'hFE, 1'b0, 28'h0};
      20: r = {CMD_FEED, 8'hFF, 1'b0, 28'h0};
      21: r = {CMD_PULL, 8'h00, 1'b1, result_of(1, 8'h00, 0, 0, 1, 16'd9)};
      22: r = {CMD_PULL, 8'h00, 1'b0, 28'h0};
      23: r = {CMD_PULL, 8'h00, 1'b0, 28'h0};
      24: r = {CMD_FEED, 8'hFE, 1'b0, 28'h0};  // fill with a count of zero
      25: r = {CMD_FEED, 8'h00, 1'b0, 28'h0};
      26: r = {CMD_FEED, 8'h00, 1'b0, 28'h0};
      default: r = {CMD_FEED, 8'hAB, 1'b0, 28'h0};
    endcase
    return r;
  endfunction

  // Receiver: random back-pressure, plus long hold-offs on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 6);
      end
    end
  end

  // Compare each result taken with the oldest one pending
  always @(posedge clk_i) begin : result_check
    lcw_res_t got;
    lcw_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        got  = lcw_res_t'(m_axis_tdata[27:0]);
        if (got.has_byte !== want.has_byte)
          report_mismatch("has_byte", got.has_byte, want.has_byte);
        if (got.data_byte !== want.data_byte)
          report_mismatch("data_byte", got.data_byte, want.data_byte);
        if (got.needs_source !== want.needs_source)
          report_mismatch("needs_source", got.needs_source, want.needs_source);
        if (got.finished !== want.finished)
          report_mismatch("finished", got.finished, want.finished);
        if (got.bad_reference !== want.bad_reference)
          report_mismatch("bad_reference", got.bad_reference, want.bad_reference);
        if (got.out_count !== want.out_count)
          report_mismatch("out_count", got.out_count, want.out_count);
        if (m_axis_tdata[31:28] !== 4'h0)
          report_mismatch("tdata padding", m_axis_tdata[31:28], 0);
      end
    end
  end

  initial begin : main_seq
    dir_row_t row;
    int unsigned ending;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 16'h0000;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = CMD_FEED;
    err_count     = 0;
    gaps_on       = 1'b1;
    rx_hold_req   = 0;
    abs_target    = 16'h0000;
    wr_pos        = 0;
    dec_phase     = PH_OPCODE;
    op_hold       = 8'h00;
    run_cnt       = 0;
    src_pos       = 0;
    held_byte     = 8'h00;
    dec_done      = 1'b0;
    len_limit     = LEN_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_row(i);
      send_request(row.cmd, row.src, row.typed, row.res);
    end

    wait_results_drained();
    write_length(16'hFFFF);
    run_random(330);

    // No idling on either side for this stretch
    wait_results_drained();
    write_length(16'd60000);
    gaps_on = 1'b0;
    run_random(330);

    // Hold the receiver off long enough to fill the block
    wait_results_drained();
    write_length(16'($urandom_range(65535, 4000)));
    gaps_on     = 1'b1;
    rx_hold_req = 300;
    run_random(330);

    wait_results_drained();
    write_length(16'd40000);
    run_random(307);

    // Close the stream: exit code, a clipped run, or a lowered length
    ending = $urandom_range(2);
    if (ending == 0) begin
      finish_operation();
      send_request(CMD_FEED, OP_EXIT, 1'b0, '0);
    end else if (ending == 1) begin
      finish_operation();
      wait_results_drained();
      write_length(16'(wr_pos + $urandom_range(20, 1)));
      send_request(CMD_FEED, OP_FILL, 1'b0, '0);
      send_request(CMD_FEED, 8'hFF, 1'b0, '0);
      send_request(CMD_FEED, 8'hFF, 1'b0, '0);
      send_request(CMD_FEED, 8'($urandom_range(255)), 1'b0, '0);
      while (!dec_done)
        send_request(CMD_PULL, 8'h00, 1'b0, '0);
    end else begin
      wait_results_drained();
      write_length(16'd1);
    end

    // Finished must stick whatever comes next
    send_request(CMD_PULL, 8'h00, 1'b0, '0);
    send_request(CMD_FEED, OP_EXIT, 1'b0, '0);
    send_request(CMD_FEED, 8'($urandom_range(255)), 1'b0, '0);
    send_request(CMD_PULL, 8'hFF, 1'b0, '0);
    wait_results_drained();
    write_length(16'd1);
    write_length(16'd0);
    send_request(CMD_FEED, 8'h81, 1'b0, '0);
    send_request(CMD_PULL, 8'h00, 1'b0, '0);

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("lcw_format80_decompressor test passed");
    else
      $display("lcw_format80_decompressor test failed");
    $finish;
  end

endmodule
